[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the bit field decoder.
// No dependencies; each macro expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every rising clock edge outside reset.
`define BFD_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger implies a consequence at the same edge.
`define BFD_ASSERT_IMPL(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Checks that a trigger implies a consequence at the next edge.
`define BFD_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[rtl/bfd_pkg.sv]
// Package of the bit field decoder: mode and register codes, character constants
// and the character mapping used by the decoder. No dependencies.
`timescale 1ns / 1ps

package bfd_pkg;

  // Decode modes.
  localparam logic [2:0] MODE_UNSIGNED = 3'd0;
  localparam logic [2:0] MODE_SIGNED   = 3'd1;
  localparam logic [2:0] MODE_SIX      = 3'd2;
  localparam logic [2:0] MODE_HEX      = 3'd3;
  localparam logic [2:0] MODE_OCT      = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FIRST_BIT = 2'd0;
  localparam logic [1:0] REG_LAST_BIT  = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;

  localparam int APB_ADDR_W = 4;
  localparam int BIT_NUM_W  = 8;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_WIDTH = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  // Field value width and packed output word width.
  localparam int VALUE_W = 33;
  localparam int OUT_W   = 48;

  // Maps one completed bit group to its character.
  function automatic logic [7:0] text_char(input logic [2:0] mode, input logic [5:0] code);
    logic [7:0] ch;
    ch = 8'd0;
    case (mode)
      MODE_SIX: begin
        if (code inside {[6'd1:6'd26]}) begin
          ch = CH_A + {2'b00, code} - 8'd1;
        end else if (code inside {[6'd48:6'd57]}) begin
          ch = CH_ZERO + {2'b00, code} - 8'd48;
        end else begin
          ch = CH_SPACE;
        end
      end
      MODE_HEX: begin
        if (code[3:0] < 4'd10) begin
          ch = CH_ZERO + {4'b0000, code[3:0]};
        end else begin
          ch = CH_A + {4'b0000, code[3:0]} - 8'd10;
        end
      end
      MODE_OCT: ch = CH_ZERO + {5'b00000, code[2:0]};
      default:  ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

[rtl/bit_field_decoder.sv]
// Top level of the bit field decoder: stream ports, configuration registers,
// sequencer and output register. Depends on bfd_pkg, bfd_byte_store and
// assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// Bytes of one item arrive on the s_axis channel, first byte first, with
// s_axis_tlast on the final byte. One byte is taken per cycle while loading.
// The final byte starts decoding and s_axis_tready stays low until the last
// result of the item has been handed to the output register.
// Decoding passes a check state, then walks the field one bit per cycle through
// the shared bit extraction unit (fields of at most 128 bits), holding while a
// result is ready but the output register is still full. An error answer gives
// one result, or three in a text mode, each once the output register is free.
// Results leave on m_axis as requests; m_axis_tlast marks the last one of an
// item. A stalled receiver holds the result in the output register and the
// sequencer waits on the next result. The registers first_bit, last_bit and
// decode_mode sit at byte addresses 0, 4 and 8 of the APB port; the user sees
// they are written only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) empties the byte count, drops any result in flight
// and restores the register defaults; no byte is taken while it is high.
module bit_field_decoder #(
  parameter int MAX_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tlast,   // final_byte
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bfd_pkg::OUT_W-1:0]       m_axis_tdata,   // [32:0] field_value,
                                                          // [40:33] char_code,
                                                          // [42:41] status,
                                                          // [47:43] zero
  output logic                            m_axis_tlast    // end_of_run
);
  import bfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_CHECK = 4'b0010,
    S_WALK  = 4'b0100,
    S_ERR   = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [7:0] first_bit;
  logic [7:0] last_bit;
  logic [2:0] decode_mode;

  // Item state
  logic [CNT_W-1:0] byte_count;
  logic             overflow_seen;

  // Walk state
  logic [7:0]         pos;
  logic [7:0]         remaining;
  logic [2:0]         grp_len;
  logic [2:0]         grp_cnt;
  logic [VALUE_W-1:0] acc;
  logic [5:0]         code;
  logic               first;
  logic               is_text;
  logic [1:0]         err_status;
  logic [1:0]         err_left;

  // Output register
  logic [VALUE_W-1:0] out_value;
  logic [7:0]         out_char;
  logic [1:0]         out_status;

  logic cfg_wr;
  logic in_accept;
  logic out_free;
  logic store_wr;
  logic bit_val;

  // Check cycle signals
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic [8:0]  nb9;
  logic [17:0] prod;
  logic [5:0]  q6;
  logic [6:0]  q3;
  logic        text_mode;
  logic        unknown_mode;
  logic        range_err;
  logic        width_err;
  logic [2:0]  grp_sel;

  // Walk cycle signals
  logic [VALUE_W-1:0] acc_base;
  logic [VALUE_W-1:0] acc_new;
  logic [5:0]         code_new;
  logic               walk_last;
  logic               walk_emit;
  logic               walk_adv;

  // Result request toward the output register
  logic               push;
  logic [VALUE_W-1:0] push_value;
  logic [7:0]         push_char;
  logic [1:0]         push_status;
  logic               push_last;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = (state == S_LOAD) & ~rst;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign store_wr      = in_accept & (byte_count < CNT_W'(MAX_BYTES));
  assign m_axis_tdata  = {5'b00000, out_status, out_char, out_value};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_bit   <= 8'd1;
      last_bit    <= 8'd8;
      decode_mode <= MODE_UNSIGNED;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST_BIT: first_bit   <= pwdata[7:0];
        REG_LAST_BIT:  last_bit    <= pwdata[7:0];
        REG_MODE:      decode_mode <= pwdata[2:0];
        default:       ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (paddr[3:2])
      REG_FIRST_BIT: prdata = {24'd0, first_bit};
      REG_LAST_BIT:  prdata = {24'd0, last_bit};
      REG_MODE:      prdata = {29'd0, decode_mode};
      default:       prdata = 32'd0;
    endcase
  end

  // Shared bit extraction unit over the stored bytes.
  bfd_byte_store #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_idx  (byte_count[IDX_W-1:0]),
    .wr_data (s_axis_tdata),
    .bit_num (pos),
    .count   (byte_count),
    .bit_out (bit_val)
  );

  // Range and width checks for the current item.
  always_comb begin
    if (first_bit > last_bit) begin
      lo_b = last_bit;
      hi_b = first_bit;
    end else begin
      lo_b = first_bit;
      hi_b = last_bit;
    end
    nb9          = {1'b0, hi_b} - {1'b0, lo_b} + 9'd1;
    // Reciprocal of 6 in 12 fractional bits, exact for widths below 256.
    prod         = 18'(nb9[7:0]) * 18'd683;
    q6           = prod[17:12];
    q3           = prod[17:11];
    text_mode    = (decode_mode == MODE_SIX) || (decode_mode == MODE_HEX) ||
                   (decode_mode == MODE_OCT);
    unknown_mode = (decode_mode > MODE_OCT);
    range_err    = overflow_seen || (lo_b == 8'd0) ||
                   ({1'b0, hi_b} > 9'({byte_count, 3'b000}));
    case (decode_mode)
      MODE_SIX: begin
        grp_sel   = 3'd6;
        width_err = (9'({q6, 2'b00}) + 9'({q6, 1'b0})) != nb9;
      end
      MODE_HEX: begin
        grp_sel   = 3'd4;
        width_err = nb9[1:0] != 2'b00;
      end
      MODE_OCT: begin
        grp_sel   = 3'd3;
        width_err = (9'({q3, 1'b0}) + 9'(q3)) != nb9;
      end
      default: begin
        grp_sel   = 3'd1;
        width_err = nb9 > 9'd32;
      end
    endcase
  end

  // Walk step: shift in one bit, emit a result on a finished group or field.
  always_comb begin
    acc_base  = (first && (decode_mode == MODE_SIGNED)) ? {VALUE_W{bit_val}} : acc;
    acc_new   = {acc_base[VALUE_W-2:0], bit_val};
    code_new  = {code[4:0], bit_val};
    walk_last = (remaining == 8'd1);
    walk_emit = is_text ? (grp_cnt == 3'd1) : walk_last;
    walk_adv  = ~walk_emit | out_free;
  end

  // Result request selection
  always_comb begin
    push        = 1'b0;
    push_value  = '0;
    push_char   = 8'd0;
    push_status = ST_OK;
    push_last   = 1'b0;
    case (state)
      S_WALK: begin
        push      = walk_emit & out_free;
        push_last = walk_last;
        if (is_text) begin
          push_char = text_char(decode_mode, code_new);
        end else begin
          push_value = acc_new;
        end
      end
      S_ERR: begin
        push        = out_free;
        push_char   = is_text ? CH_QUERY : 8'd0;
        push_status = err_status;
        push_last   = (err_left == 2'd1);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      err_left      <= 2'd0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (store_wr) begin
              byte_count <= byte_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          is_text   <= text_mode;
          pos       <= hi_b;
          remaining <= nb9[7:0];
          grp_len   <= grp_sel;
          grp_cnt   <= grp_sel;
          acc       <= '0;
          code      <= 6'd0;
          first     <= 1'b1;
          if (unknown_mode) begin
            err_status <= ST_WIDTH;
            err_left   <= 2'd1;
            state      <= S_ERR;
          end else if (range_err || width_err) begin
            err_status <= range_err ? ST_RANGE : ST_WIDTH;
            err_left   <= text_mode ? 2'd3 : 2'd1;
            state      <= S_ERR;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_adv) begin
            pos       <= pos - 8'd1;
            remaining <= remaining - 8'd1;
            first     <= 1'b0;
            acc       <= acc_new;
            code      <= walk_emit ? 6'd0 : code_new;
            grp_cnt   <= (grp_cnt == 3'd1) ? grp_len : grp_cnt - 3'd1;
            if (walk_last) begin
              byte_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            err_left <= err_left - 2'd1;
            if (err_left == 2'd1) begin
              byte_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output register: valid with reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_value    <= push_value;
      out_char     <= push_char;
      out_status   <= push_status;
      m_axis_tlast <= push_last;
    end
  end

  // Assertions
  `BFD_ASSERT(a_count_bound, byte_count <= CNT_W'(MAX_BYTES), "byte count past store depth")
  `BFD_ASSERT_IMPL(a_overflow_full, overflow_seen, byte_count == CNT_W'(MAX_BYTES), "overflow with room left")
  `BFD_ASSERT_IMPL(a_walk_bits, state == S_WALK, (remaining != 8'd0) && (pos != 8'd0), "walk past the field")
  `BFD_ASSERT_NEXT(a_push_valid, push, m_axis_tvalid, "pushed result not presented")

endmodule

[rtl/bfd_byte_store.sv]
// Byte store of the bit field decoder: holds the bytes of one item and returns
// one addressed bit per cycle. Depends on bfd_pkg.
`timescale 1ns / 1ps

module bfd_byte_store #(
  parameter int MAX_BYTES = 16,
  parameter int CNT_W     = $clog2(MAX_BYTES + 1),
  parameter int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [IDX_W-1:0]                  wr_idx,
  input  logic [7:0]                        wr_data,
  input  logic [bfd_pkg::BIT_NUM_W-1:0]     bit_num,
  input  logic [CNT_W-1:0]                  count,
  output logic                              bit_out
);
  import bfd_pkg::*;

  logic [7:0]           mem [MAX_BYTES];
  logic [BIT_NUM_W-1:0] off;
  logic [BIT_NUM_W-1:0] idx_full;
  logic [IDX_W-1:0]     rd_idx;

  // Write the incoming byte; the store has no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Bit 1 is the LSB of the last stored byte, so count back from the end.
  always_comb begin
    off      = bit_num - 8'd1;
    idx_full = BIT_NUM_W'(count) - 8'd1 - {3'b000, off[7:3]};
    rd_idx   = idx_full[IDX_W-1:0];
    bit_out  = mem[rd_idx][off[2:0]];
  end

endmodule

[bench/tb.sv]
// Self-checking bench for bit_field_decoder: APB register setup, random byte
// streams with bursty sender and stalling receiver, and an in-bench decoder.
// Depends on bfd_pkg and the RTL of bit_field_decoder.
`timescale 1ns / 1ps

module tb;
  import bfd_pkg::*;

  localparam int MAX_BYTES = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 16;
  localparam int PHASE_BYTES = 20;
  // Mode codes with no decoder behind them.
  localparam logic [2:0] MODE_UNUSED_MIN = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MAX = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [32:0] value;
    logic [7:0]  chr;
    logic [1:0]  st;
    logic        eor;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [32:0] field_value, [40:33] char_code,
                                   // [42:41] status, [47:43] zero
  logic        m_axis_tlast;       // end_of_run

  // Bytes waiting to be sent and results the decoder should produce.
  stream_byte_t  byte_queue[$];
  field_result_t expected_results[$];

  // Bench copy of the registers and of the item being collected.
  logic [7:0] cfg_first = 8'd1;
  logic [7:0] cfg_last = 8'd8;
  logic [2:0] cfg_mode = MODE_UNSIGNED;
  logic [7:0] frame_bytes[MAX_BYTES];
  int         frame_len = 0;
  logic       frame_dropped = 1'b0;

  int   errors = 0;
  logic full_speed = 1'b0;
  int   hold_token = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   open_left = 0;
  int   shut_left = 0;
  int   burst_left = 0;
  int   gap_left = 0;

  bit_field_decoder #(.MAX_BYTES(MAX_BYTES)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Bits hi down to lo of the collected item, bit 1 being the LSB of the final byte.
  function automatic logic [63:0] field_bits(input int lo, input int hi);
    logic [63:0] v;
    int b;
    int off;
    v = '0;
    for (b = hi; b >= lo; b--) begin
      off = b - 1;
      v = {v[62:0], frame_bytes[frame_len - 1 - off / 8][off % 8]};
    end
    return v;
  endfunction

  task automatic push_result(input logic [32:0] value, input logic [7:0] chr,
                             input logic [1:0] st, input logic eor);
    field_result_t r;
    r.value = value;
    r.chr = chr;
    r.st = st;
    r.eor = eor;
    expected_results.push_back(r);
  endtask

  // Works out the results for the final byte of an item.
  task automatic decode_frame();
    int lo;
    int hi;
    int nb;
    int grp;
    int nchar;
    int top;
    int i;
    logic [1:0]  st;
    logic [63:0] v;
    logic [5:0]  code;
    logic [7:0]  ch;
    logic        text;
    lo = cfg_first;
    hi = cfg_last;
    if (cfg_mode > MODE_OCT) begin
      push_result('0, '0, ST_WIDTH, 1'b1);
      return;
    end
    if (lo > hi) begin
      lo = cfg_last;
      hi = cfg_first;
    end
    nb = hi - lo + 1;
    text = (cfg_mode >= MODE_SIX);
    grp = (cfg_mode == MODE_SIX) ? 6 : (cfg_mode == MODE_HEX) ? 4 : 3;
    // The range check takes precedence over the width check.
    if (frame_dropped || lo < 1 || hi > 8 * frame_len) begin
      st = ST_RANGE;
    end else if (!text) begin
      st = (nb > 32) ? ST_WIDTH : ST_OK;
    end else begin
      st = (nb % grp != 0) ? ST_WIDTH : ST_OK;
    end

    if (!text) begin
      if (st != ST_OK) begin
        push_result('0, '0, st, 1'b1);
      end else begin
        v = field_bits(lo, hi);
        if (cfg_mode == MODE_SIGNED && v[nb - 1]) begin
          v = v | ~((64'd1 << nb) - 64'd1);
        end
        push_result(v[32:0], '0, ST_OK, 1'b1);
      end
    end else if (st != ST_OK) begin
      push_result('0, CH_QUERY, st, 1'b0);
      push_result('0, CH_QUERY, st, 1'b0);
      push_result('0, CH_QUERY, st, 1'b1);
    end else begin
      // One character per bit group, most significant group first.
      nchar = nb / grp;
      for (i = 0; i < nchar; i++) begin
        top = hi - i * grp;
        v = field_bits(top - grp + 1, top);
        code = v[5:0];
        if (cfg_mode == MODE_SIX) begin
          if (code >= 6'd1 && code <= 6'd26) begin
            ch = CH_A + {2'b00, code} - 8'd1;
          end else if (code >= 6'd48 && code <= 6'd57) begin
            ch = CH_ZERO + {2'b00, code} - 8'd48;
          end else begin
            ch = CH_SPACE;
          end
        end else if (cfg_mode == MODE_HEX) begin
          ch = (code < 6'd10) ? CH_ZERO + {2'b00, code} : CH_A + {2'b00, code} - 8'd10;
        end else begin
          ch = CH_ZERO + {2'b00, code};
        end
        push_result('0, ch, ST_OK, i == nchar - 1);
      end
    end
  endtask

  // Stores one accepted byte; bytes past the store are dropped and remembered.
  task automatic absorb_byte(input logic [7:0] data, input logic last);
    if (frame_len < MAX_BYTES) begin
      frame_bytes[frame_len] = data;
      frame_len++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (last) begin
      decode_frame();
      frame_len = 0;
      frame_dropped = 1'b0;
    end
  endtask

  // Byte sender: bursts of random length separated by random gaps (none at full speed).
  always @(posedge clk) begin : byte_driver
    logic sent;
    sent = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (sent) begin
        absorb_byte(s_axis_tdata, s_axis_tlast);
        void'(byte_queue.pop_front());
      end
      // A pending request is held until it is taken.
      if (!s_axis_tvalid || sent) begin
        if (gap_left > 0 && !full_speed) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= byte_queue[0].data;
          s_axis_tlast <= byte_queue[0].last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: open/stall pattern, open at full speed, plus one long hold-off on request.
  always @(posedge clk) begin : result_sink
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (full_speed) begin
      m_axis_tready <= 1'b1;
    end else if (open_left > 0) begin
      open_left--;
      m_axis_tready <= 1'b1;
    end else if (shut_left > 0) begin
      shut_left--;
      m_axis_tready <= 1'b0;
    end else begin
      open_left = $urandom_range(1, 10);
      shut_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [32:0] want,
                               input logic [32:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    field_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("field_value", want.value, m_axis_tdata[32:0]);
        compare_field("char_code", want.chr, m_axis_tdata[40:33]);
        compare_field("status", want.st, m_axis_tdata[42:41]);
        compare_field("padding", '0, m_axis_tdata[47:43]);
        compare_field("end_of_run", want.eor, m_axis_tlast);
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FIRST_BIT: cfg_first = val;
      REG_LAST_BIT:  cfg_last = val;
      REG_MODE:      cfg_mode = val[2:0];
      default:       ;
    endcase
  endtask

  // Waits until every byte is taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || expected_results.size() != 0 || s_axis_tvalid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] first, input logic [7:0] last,
                            input logic [2:0] mode);
    wait_idle();
    apb_write(REG_FIRST_BIT, first);
    apb_write(REG_LAST_BIT, last);
    apb_write(REG_MODE, mode);
  endtask

  task automatic add_byte(input logic [7:0] data, input logic last);
    stream_byte_t b;
    b.data = data;
    b.last = last;
    byte_queue.push_back(b);
  endtask

  // Mostly items long enough for the field, some short, some too long.
  task automatic run_phase(input logic [7:0] first, input logic [7:0] last,
                           input logic [2:0] mode, input logic fast);
    int need;
    int added;
    int len;
    int r;
    int k;
    set_config(first, last, mode);
    full_speed = fast;
    need = (((first > last) ? first : last) + 7) / 8;
    if (need < 1) need = 1;
    if (need > MAX_BYTES) need = MAX_BYTES;
    added = 0;
    while (added < PHASE_BYTES) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 4);
      end else if (r == 1) begin
        len = $urandom_range(1, MAX_BYTES);
      end else begin
        len = $urandom_range(need, MAX_BYTES);
      end
      for (k = 0; k < len; k++) begin
        add_byte($urandom_range(0, 255), k == len - 1);
      end
      added += len;
    end
  endtask

  // Random register setting, mostly a well-formed field for the chosen mode.
  task automatic pick_config(output logic [7:0] first, output logic [7:0] last,
                             output logic [2:0] mode);
    int pick;
    int grp;
    int width;
    int lo;
    int hi;
    if ($urandom_range(0, 19) == 0) begin
      pick = $urandom_range(MODE_UNUSED_MIN, MODE_UNUSED_MAX);
    end else begin
      pick = $urandom_range(MODE_UNSIGNED, MODE_OCT);
    end
    mode = pick[2:0];
    grp = (mode == MODE_SIX) ? 6 : (mode == MODE_HEX) ? 4 : 3;
    if ($urandom_range(0, 9) == 0) begin
      lo = $urandom_range(0, 255);
      hi = $urandom_range(0, 255);
    end else begin
      if (mode < MODE_SIX || mode > MODE_OCT) begin
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 32);
      end else begin
        width = grp * $urandom_range(1, 128 / grp);
        if ($urandom_range(0, 7) == 0 && width < 128) width += 1;
      end
      lo = $urandom_range(1, 129 - width);
      hi = lo + width - 1;
    end
    if ($urandom_range(0, 1) == 1) begin
      first = hi[7:0];
      last = lo[7:0];
    end else begin
      first = lo[7:0];
      last = hi[7:0];
    end
  endtask

  initial begin
    int p;
    logic [7:0] f;
    logic [7:0] l;
    logic [2:0] m;
    do @(posedge clk);
    while (rst);

    // Reset values: the final byte read as an unsigned byte.
    add_byte(8'hFF, 1'b1);

    // Reversed bounds over a full 32-bit signed field.
    set_config(8'd32, 8'd1, MODE_SIGNED);
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h01, 1'b1);

    // A 33-bit field: past a 4-byte item the range error wins, else a width error.
    set_config(8'd1, 8'd33, MODE_UNSIGNED);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h04, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h04, 1'b1);

    // A mode code with no decoder.
    set_config(8'd1, 8'd8, MODE_UNUSED_MAX);
    add_byte(8'h00, 1'b1);

    // Six-bit characters: a letter and a digit.
    set_config(8'd1, 8'd12, MODE_SIX);
    add_byte(8'h04, 1'b0);
    add_byte(8'h79, 1'b1);

    // Hex characters, then a width that is not a whole number of nibbles.
    set_config(8'd1, 8'd8, MODE_HEX);
    add_byte(8'hAF, 1'b1);
    set_config(8'd1, 8'd6, MODE_HEX);
    add_byte(8'h55, 1'b1);

    // Octal with a first bit of zero gives a range error as text.
    set_config(8'd0, 8'd9, MODE_OCT);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b1);

    // Random phases; the first three cover the widest fields and the top bit.
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        run_phase(8'd1, 8'd128, MODE_HEX, 1'b0);
        hold_token++;
      end else if (p == 1) begin
        run_phase(8'd128, 8'd3, MODE_OCT, 1'b0);
      end else if (p == 2) begin
        run_phase(8'd128, 8'd128, MODE_UNSIGNED, 1'b0);
      end else begin
        pick_config(f, l, m);
        run_phase(f, l, m, p % 5 == 3);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bfd_pkg.sv
rtl/bfd_byte_store.sv
rtl/bit_field_decoder.sv
bench/tb.sv
